FILE: sv/assert_macros.svh
// Assertion helpers, clocked on clk; ASSERT_CLK is disabled in reset, ASSERT_CLK_RST is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/fte_pkg.sv
package fte_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_COUNT_BITS  = 32;

  localparam int PORT_KEY_W = 64;
  localparam int PORT_CNT_W = 32;
  localparam int STATUS_W   = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_INCR  = 3'd0;
  localparam status_t ST_NEW   = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_DONE  = 3'd3;
  localparam status_t ST_EMPTY = 3'd4;

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } fsm_t;

endpackage

FILE: sv/frequency_table_extract_max_unit.sv
// Sequencing: an extract or a missed insert scans every used entry, an insert that matches
// entry i stops the scan there, and on an empty table no scan is made; the result then waits
// for the output register to be free; one entry is read and compared per cycle.
// Throughput: one transaction at a time, s_tready is high only while idle, so
// the next one is accepted at the earliest in the cycle in which m_tvalid rises.
// Reset: rst (synchronous) empties the table; stored keys and counts keep no reset value.
`include "assert_macros.svh"

module frequency_table_extract_max_unit
  import fte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [PORT_KEY_W-1:0]            s_tdata,  // [63:0] key
  input  logic [0:0]                       s_tuser,  // [0] req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [PORT_KEY_W+PORT_CNT_W-1:0] m_tdata,  // [63:0] out_key, [95:64] out_count
  output logic [STATUS_W-1:0]              m_tuser   // [2:0] status
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);

  logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];

  fsm_t state, state_next;
  logic [USED_W-1:0] used;
  logic [ADDR_W-1:0] idx;
  logic              issued_all;
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_idx;
  logic              rd_last;
  logic [KEY_BITS-1:0]   key_q;
  logic [COUNT_BITS-1:0] cnt_q;

  logic                  req_type;
  logic [KEY_BITS-1:0]   req_key;
  logic [ADDR_W-1:0]     best_idx, best_idx_next;
  logic [COUNT_BITS-1:0] best_cnt, best_cnt_next;
  logic [KEY_BITS-1:0]   best_key, best_key_next;

  status_t               res_status, res_status_next;
  logic [KEY_BITS-1:0]   res_key, res_key_next;
  logic [COUNT_BITS-1:0] res_cnt, res_cnt_next;
  logic                  res_load;

  logic [KEY_BITS-1:0]   out_key;
  logic [COUNT_BITS-1:0] out_cnt;
  status_t               out_status;

  logic                  in_fire, out_load, rd_en, used_inc;
  logic                  wr_key_en, wr_cnt_en;
  logic [ADDR_W-1:0]     wr_cnt_addr;
  logic [COUNT_BITS-1:0] wr_cnt_data;
  logic [KEY_BITS-1:0]   app_key;
  logic                  key_hit, cnt_gt, sel, full;
  logic [USED_W-1:0]     used_m1;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);
  assign rd_en    = (state == S_SCAN) && !issued_all;
  assign full     = (used == USED_W'(TABLE_DEPTH));
  assign used_m1  = used - 1'b1;
  assign key_hit  = (key_q == req_key);
  assign cnt_gt   = (cnt_q > best_cnt);
  assign sel      = (rd_idx == '0) || cnt_gt;
  assign app_key  = (state == S_IDLE) ? s_tdata[KEY_BITS-1:0] : req_key;

  assign m_tdata  = {PORT_CNT_W'(out_cnt), PORT_KEY_W'(out_key)};
  assign m_tuser  = out_status;

  always_comb begin
    state_next      = state;
    res_load        = 1'b0;
    res_status_next = res_status;
    res_key_next    = '0;
    res_cnt_next    = '0;
    wr_key_en       = 1'b0;
    wr_cnt_en       = 1'b0;
    wr_cnt_addr     = used[ADDR_W-1:0];
    wr_cnt_data     = COUNT_BITS'(1);
    used_inc        = 1'b0;
    best_idx_next   = sel ? rd_idx : best_idx;
    best_cnt_next   = sel ? cnt_q : best_cnt;
    best_key_next   = sel ? key_q : best_key;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (used == '0) begin
            state_next = S_FINISH;
            res_load   = 1'b1;
            if (s_tuser[0] == REQ_INSERT) begin
              wr_key_en       = 1'b1;
              wr_cnt_en       = 1'b1;
              used_inc        = 1'b1;
              res_status_next = ST_NEW;
              res_cnt_next    = COUNT_BITS'(1);
            end else begin
              res_status_next = ST_EMPTY;
            end
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_valid) begin
          if (req_type == REQ_INSERT) begin
            if (key_hit) begin
              wr_cnt_en       = 1'b1;
              wr_cnt_addr     = rd_idx;
              wr_cnt_data     = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
              res_load        = 1'b1;
              res_status_next = ST_INCR;
              res_cnt_next    = wr_cnt_data;
              state_next      = S_FINISH;
            end else if (rd_last) begin
              res_load   = 1'b1;
              state_next = S_FINISH;
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                wr_key_en       = 1'b1;
                wr_cnt_en       = 1'b1;
                used_inc        = 1'b1;
                res_status_next = ST_NEW;
                res_cnt_next    = COUNT_BITS'(1);
              end
            end
          end else if (rd_last) begin
            wr_cnt_en       = 1'b1;
            wr_cnt_addr     = best_idx_next;
            wr_cnt_data     = '0;
            res_load        = 1'b1;
            res_status_next = ST_DONE;
            res_key_next    = best_key_next;
            res_cnt_next    = best_cnt_next;
            state_next      = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table memories, one key write, one count write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[used[ADDR_W-1:0]] <= app_key;
    end
    if (wr_cnt_en) begin
      cnt_mem[wr_cnt_addr] <= wr_cnt_data;
    end
    if (rd_en) begin
      key_q <= key_mem[idx];
      cnt_q <= cnt_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      m_tvalid   <= 1'b0;
      rd_valid   <= 1'b0;
      issued_all <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (used_inc) begin
        used <= used + 1'b1;
      end
      if (in_fire) begin
        idx        <= '0;
        issued_all <= 1'b0;
        rd_valid   <= 1'b0;
      end else if (state == S_SCAN) begin
        rd_valid <= rd_en;
        if (rd_en) begin
          idx        <= idx + 1'b1;
          issued_all <= (USED_W'(idx) == used_m1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type <= s_tuser[0];
      req_key  <= s_tdata[KEY_BITS-1:0];
    end
    if (rd_en) begin
      rd_idx  <= idx;
      rd_last <= (USED_W'(idx) == used_m1);
    end
    if (state == S_SCAN && rd_valid) begin
      best_idx <= best_idx_next;
      best_cnt <= best_cnt_next;
      best_key <= best_key_next;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_key    <= res_key_next;
      res_cnt    <= res_cnt_next;
    end
    if (out_load) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_cnt    <= res_cnt;
    end
  end

  `ASSERT_CLK(a_used_bound, used <= USED_W'(TABLE_DEPTH), "entry count above table depth")
  `ASSERT_CLK(a_used_step, !$stable(used) |-> (used == $past(used) + 1'b1),
              "entry count changed by other than one")
  `ASSERT_CLK(a_accept_leaves_idle, in_fire |=> (state != S_IDLE),
              "accepted transaction left sequencer idle")
  `ASSERT_CLK(a_no_rw_clash, !(rd_en && wr_key_en),
              "key write during scan read")

endmodule
